// File: rtl/stick_radial_deadzone_core_assert.svh
// Assertion macros for the stick radial dead zone core.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef STICK_RADIAL_DEADZONE_CORE_ASSERT_SVH
`define STICK_RADIAL_DEADZONE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SRDZ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("srdz assertion failed");
`define SRDZ_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("srdz assertion failed");
`else
`define SRDZ_ASSERT(lbl, prop)
`define SRDZ_ASSERT_NR(lbl, prop)
`endif
`endif

// File: rtl/srdz_pkg.sv
// Shared types, constants and arithmetic helpers of the stick radial dead zone core.
// No dependencies.
package srdz_pkg;

  localparam int NUM_DEVICES       = 4;
  localparam int STICKS_PER_DEVICE = 4;
  localparam int ROWS              = NUM_DEVICES * STICKS_PER_DEVICE;
  localparam int ROW_W             = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int QDEPTH            = 2;
  localparam int QPTR_W            = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W            = $clog2(QDEPTH + 1);

  localparam logic [0:0]  CFG_INNER = 1'b0;
  localparam logic [0:0]  CFG_OUTER = 1'b1;
  localparam logic [15:0] ONE_Q15   = 16'h8000;
  localparam logic [15:0] INNER_RST = 16'h0000;
  localparam logic [15:0] OUTER_RST = 16'h8000;

  typedef struct packed {
    logic [1:0]  device_index;
    logic [1:0]  stick_index;
    logic        axis_index;
    logic        negative_dir;
    logic [14:0] axis_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         out_device;
    logic [1:0]         out_stick;
    logic signed [15:0] clean_x;
    logic signed [15:0] clean_y;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         dev;
    logic [1:0]         stk;
    logic               ok;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef enum logic {F_IDLE, F_MERGE} front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_SQX, B_SQY, B_SQRT, B_CHK, B_SDIV, B_CMUL, B_CCHK, B_CDIV, B_DONE
  } back_state_t;

  typedef struct packed {
    logic [15:0] rem;
    logic        q;
  } div_step_t;

  // One restoring division step: shift in one numerator bit.
  function automatic div_step_t div_step(input logic [15:0] rem, input logic nbit,
                                         input logic [15:0] dvs);
    logic [16:0] t;
    div_step_t   res;
    t = {rem, nbit};
    if (t >= {1'b0, dvs}) begin
      res.rem = 16'(t - {1'b0, dvs});
      res.q   = 1'b1;
    end else begin
      res.rem = t[15:0];
      res.q   = 1'b0;
    end
    return res;
  endfunction

  // Apply sign and saturate a component magnitude to signed Q1.15.
  function automatic logic signed [15:0] sat_comp(input logic neg, input logic ovf,
                                                  input logic [15:0] q);
    logic signed [15:0] res;
    if (neg) begin
      if (ovf || q >= 16'h8000) res = 16'sh8000;
      else                      res = -$signed(q);
    end else begin
      if (ovf || q > 16'h7fff) res = 16'sh7fff;
      else                     res = $signed(q);
    end
    return res;
  endfunction

endpackage

// File: rtl/srdz_front.sv
// Front end: accepts axis events, updates the raw stick table and queues jobs.
// Depends on srdz_pkg.
module srdz_front (
  input  logic             clk,
  input  logic             rst_n,
  input  srdz_pkg::in_item_t in_item,
  input  logic             in_valid,
  output logic             in_stall,
  output srdz_pkg::job_t   job,
  output srdz_pkg::q_wr_t  qwr_o,
  input  logic             q_full
);
  import srdz_pkg::*;

  front_state_t state_r, state_nxt;
  in_item_t     item_r;
  logic [31:0]  mem [ROWS];
  logic [ROWS-1:0] row_vld_r;
  logic [31:0]  rd_row_r;
  logic         rd_vld_r;

  logic             accept;
  logic             in_ok, cur_ok;
  logic [ROW_W-1:0] in_addr, cur_addr;
  logic [31:0]      base_row, new_row;
  logic signed [15:0] v;
  logic             wr;

  assign accept  = in_valid && (state_r == F_IDLE);
  assign in_ok   = (int'(in_item.device_index) < NUM_DEVICES) &&
                   (int'(in_item.stick_index) < STICKS_PER_DEVICE);
  assign in_addr = ROW_W'(int'(in_item.device_index) * STICKS_PER_DEVICE +
                          int'(in_item.stick_index));
  assign cur_ok  = (int'(item_r.device_index) < NUM_DEVICES) &&
                   (int'(item_r.stick_index) < STICKS_PER_DEVICE);
  assign cur_addr = ROW_W'(int'(item_r.device_index) * STICKS_PER_DEVICE +
                           int'(item_r.stick_index));

  assign base_row = rd_vld_r ? rd_row_r : 32'h0;
  assign v = item_r.negative_dir ? -$signed({1'b0, item_r.axis_value})
                                 : $signed({1'b0, item_r.axis_value});
  // x lives in the upper half of a row, y in the lower
  assign new_row = item_r.axis_index ? {base_row[31:16], v} : {v, base_row[15:0]};
  assign wr      = qwr_o.push && cur_ok;

  assign job.dev = item_r.device_index;
  assign job.stk = item_r.stick_index;
  assign job.ok  = cur_ok;
  assign job.x   = $signed(new_row[31:16]);
  assign job.y   = $signed(new_row[15:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) rd_vld_r <= in_ok && row_vld_r[in_addr];
      if (wr) row_vld_r[cur_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r   <= in_item;
      rd_row_r <= mem[in_addr];
    end
    if (wr) mem[cur_addr] <= new_row;
  end

  always_comb begin
    state_nxt   = state_r;
    qwr_o.push  = 1'b0;
    qwr_o.full  = q_full;
    in_stall    = 1'b1;
    case (state_r)
      F_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_nxt = F_MERGE;
      end
      F_MERGE: begin
        // hold the merged row until the queue has room
        if (!q_full) begin
          qwr_o.push = 1'b1;
          state_nxt  = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

endmodule

// File: rtl/srdz_queue.sv
// Short job queue between the front end and the back end.
// Depends on srdz_pkg.
module srdz_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  srdz_pkg::q_wr_t qwr_i,
  input  srdz_pkg::job_t  din,
  output logic            full,
  input  logic            pop,
  output srdz_pkg::job_t  dout,
  output logic            empty
);
  import srdz_pkg::*;

  job_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = slot_r[rd_ptr_r];
  assign do_push = qwr_i.push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= din;
  end

endmodule

// File: rtl/srdz_back.sv
// Back end: radius by iterative square root, dead zone rescale and per-axis
// rounding divide on one shared restoring divider. Depends on srdz_pkg.
`include "stick_radial_deadzone_core_assert.svh"
module srdz_back (
  input  logic                clk,
  input  logic                rst_n,
  input  srdz_pkg::job_t      q_dout,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic [15:0]         inner,
  input  logic [15:0]         outer,
  output srdz_pkg::out_item_t out_item,
  output logic                out_valid,
  input  logic                out_stall
);
  import srdz_pkg::*;

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [31:0] prod_r, val_r, n_r;
  logic [16:0] sq_rem_r;
  logic [15:0] root_r, r_r, dvs_r, rem_r, quo_r, lo_r, scale_r;
  logic [3:0]  cnt_r;
  logic        comp_r;
  logic signed [15:0] cx_r, cy_r;
  out_item_t   out_r;
  logic        out_valid_r;

  logic [15:0] ax, ay, a_sel, m_lo, m, d0, q_nxt;
  logic [31:0] sq_x, sq_y;
  logic [18:0] t19, trial19;
  logic        sq_ge, last, neg_sel, ovf, zero_out, out_free;
  div_step_t   ds;

  assign ax      = job_r.x[15] ? 16'(-job_r.x) : job_r.x;
  assign ay      = job_r.y[15] ? 16'(-job_r.y) : job_r.y;
  assign sq_x    = ax * ax;
  assign sq_y    = ay * ay;
  assign a_sel   = comp_r ? ay : ax;
  assign neg_sel = comp_r ? job_r.y[15] : job_r.x[15];
  assign last    = (cnt_r == 4'd15);

  assign t19     = {sq_rem_r, val_r[31:30]};
  assign trial19 = {1'b0, root_r, 2'b01};
  assign sq_ge   = (t19 >= trial19);

  assign ds      = div_step(rem_r, lo_r[15], dvs_r);
  assign q_nxt   = {quo_r[14:0], ds.q};

  assign m_lo     = (root_r < inner) ? inner : root_r;
  assign m        = (m_lo > outer) ? outer : m_lo;
  assign d0       = m - inner;
  assign zero_out = (root_r == 16'h0) || (outer <= inner);
  assign ovf      = (n_r[31:16] >= r_r);
  assign out_free = !out_valid_r || !out_stall;

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = q_dout.ok ? B_SQX : B_DONE;
        end
      end
      B_SQX:  state_nxt = B_SQY;
      B_SQY:  state_nxt = B_SQRT;
      B_SQRT: if (last) state_nxt = B_CHK;
      B_CHK:  state_nxt = zero_out ? B_DONE : B_SDIV;
      B_SDIV: if (last) state_nxt = B_CMUL;
      B_CMUL: state_nxt = B_CCHK;
      B_CCHK: begin
        if (!ovf)        state_nxt = B_CDIV;
        else if (comp_r) state_nxt = B_DONE;
        else             state_nxt = B_CMUL;
      end
      B_CDIV: if (last) state_nxt = comp_r ? B_DONE : B_CMUL;
      B_DONE: if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == B_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        job_r  <= q_dout;
        comp_r <= 1'b0;
        cx_r   <= 16'sh0;
        cy_r   <= 16'sh0;
      end
      B_SQX: prod_r <= sq_x;
      B_SQY: begin
        val_r    <= prod_r + sq_y;
        sq_rem_r <= '0;
        root_r   <= '0;
        cnt_r    <= '0;
      end
      B_SQRT: begin
        sq_rem_r <= sq_ge ? 17'(t19 - trial19) : t19[16:0];
        root_r   <= {root_r[14:0], sq_ge};
        val_r    <= {val_r[29:0], 2'b00};
        cnt_r    <= cnt_r + 1'b1;
      end
      B_CHK: begin
        // numerator is d0 * 2^15, split into high and low halves
        r_r   <= root_r;
        dvs_r <= outer - inner;
        rem_r <= {1'b0, d0[15:1]};
        lo_r  <= {d0[0], 15'h0};
        quo_r <= '0;
        cnt_r <= '0;
      end
      B_SDIV: begin
        rem_r <= ds.rem;
        quo_r <= q_nxt;
        lo_r  <= {lo_r[14:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (last) scale_r <= (q_nxt > ONE_Q15) ? ONE_Q15 : q_nxt;
      end
      B_CMUL: n_r <= 32'(a_sel) * 32'(scale_r) + 32'(r_r[15:1]);
      B_CCHK: begin
        dvs_r <= r_r;
        rem_r <= n_r[31:16];
        lo_r  <= n_r[15:0];
        quo_r <= '0;
        cnt_r <= '0;
        if (ovf) begin
          if (comp_r) cy_r <= sat_comp(neg_sel, 1'b1, 16'h0);
          else        cx_r <= sat_comp(neg_sel, 1'b1, 16'h0);
          comp_r <= 1'b1;
        end
      end
      B_CDIV: begin
        rem_r <= ds.rem;
        quo_r <= q_nxt;
        lo_r  <= {lo_r[14:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          if (comp_r) cy_r <= sat_comp(neg_sel, 1'b0, q_nxt);
          else        cx_r <= sat_comp(neg_sel, 1'b0, q_nxt);
          comp_r <= 1'b1;
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_r.out_device <= job_r.dev;
          out_r.out_stick  <= job_r.stk;
          out_r.clean_x    <= cx_r;
          out_r.clean_y    <= cy_r;
        end
      end
      default: ;
    endcase
  end

  `SRDZ_ASSERT(a_pop_idle, q_pop |-> (state_r == B_IDLE))
  `SRDZ_ASSERT(a_sqrt_run, (state_r == B_SQRT && !last) |=> (state_r == B_SQRT))
  `SRDZ_ASSERT(a_scale_max, (state_r == B_CMUL) |-> (scale_r <= ONE_Q15))
  `SRDZ_ASSERT_NR(a_reset_idle, !rst_n |=> (state_r == B_IDLE && !out_valid_r))

endmodule

// File: rtl/stick_radial_deadzone_core.sv
// Stick radial dead zone core.
// Input channel in_item/in_valid/in_stall carries one stick axis event per beat.
// Output channel out_item/out_valid/out_stall returns one cleaned (x, y) per event,
// in order. Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the
// inner (index 0) and outer (index 1) dead zone radii, Q1.15; cfg_ready is always high.
// The front end takes an event, updates the raw stick table and queues a job; it takes
// no new event until that job is queued. The back end works one job at a time:
// a 16-step square root, a 16-step scale divide and two component divides on the
// shared divider; a saturated component skips its divide, and a zero result skips
// all divides.
// Throughput is set by the back end, which pops no new job until its result is registered.
// Reset clears the raw stick table (per-row valid bits), sets inner to 0 and
// outer to 1.0, and empties the queue and output register.
// While out_stall is high the result holds; the back end parks its next result
// and the two-entry queue and front end keep accepting until they fill up.
// Depends on srdz_pkg, srdz_front, srdz_queue, srdz_back.
module stick_radial_deadzone_core (
  input  logic                clk,
  input  logic                rst_n,
  input  srdz_pkg::in_item_t  in_item,
  input  logic                in_valid,
  output logic                in_stall,
  output srdz_pkg::out_item_t out_item,
  output logic                out_valid,
  input  logic                out_stall,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import srdz_pkg::*;

  logic [15:0] inner_r, outer_r;
  job_t        f_job, q_job;
  q_wr_t       qwr;
  logic        q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= INNER_RST;
      outer_r <= OUTER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INNER: inner_r <= cfg_data;
        CFG_OUTER: outer_r <= cfg_data;
        default: ;
      endcase
    end
  end

  srdz_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .job      (f_job),
    .qwr_o    (qwr),
    .q_full   (q_full)
  );

  srdz_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .qwr_i (qwr),
    .din   (f_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_job),
    .empty (q_empty)
  );

  srdz_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_dout    (q_job),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .inner     (inner_r),
    .outer     (outer_r),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule

// File: tb/sv/tb_stick_radial_deadzone_core.sv
// Testbench for the stick radial dead zone core: random and directed axis events,
// a scoreboard that predicts cleaned stick positions and checks each result beat.
// Depends on srdz_pkg and stick_radial_deadzone_core.
`timescale 1ns / 1ps

class deadzone_scoreboard;
  logic signed [15:0] raw_pos [32];
  logic [15:0] inner_r;
  logic [15:0] outer_r;
  srdz_pkg::out_item_t pending[$];
  int mismatches;

  function new();
    foreach (raw_pos[i]) raw_pos[i] = '0;
    inner_r = srdz_pkg::INNER_RST;
    outer_r = srdz_pkg::OUTER_RST;
    mismatches = 0;
  endfunction

  function void set_reg(logic [0:0] idx, logic [15:0] val);
    if (idx == srdz_pkg::CFG_INNER) inner_r = val;
    else outer_r = val;
  endfunction

  function logic [31:0] root_floor(logic [31:0] v);
    logic [31:0] root;
    logic [31:0] b;
    root = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function logic signed [15:0] component(logic signed [31:0] v, logic [31:0] sc,
                                         logic [31:0] r);
    logic [63:0] a;
    logic [63:0] q;
    a = (v < 0) ? 64'(-v) : 64'(v);
    q = (a * sc + (r >> 1)) / r;
    if (v < 0) return (q >= 32768) ? -16'sd32768 : -$signed(16'(q));
    return (q > 32767) ? 16'sd32767 : $signed(16'(q));
  endfunction

  function void note_event(srdz_pkg::in_item_t it);
    srdz_pkg::out_item_t res;
    int base;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0] r;
    logic [31:0] m;
    logic [31:0] sc;
    res.out_device = it.device_index;
    res.out_stick = it.stick_index;
    res.clean_x = '0;
    res.clean_y = '0;
    base = (int'(it.device_index) * srdz_pkg::STICKS_PER_DEVICE + int'(it.stick_index)) * 2;
    raw_pos[base + it.axis_index] = it.negative_dir ? -$signed({1'b0, it.axis_value})
                                                    : $signed({1'b0, it.axis_value});
    x = raw_pos[base];
    y = raw_pos[base + 1];
    r = root_floor(32'(x * x) + 32'(y * y));
    if (r != 0 && outer_r > inner_r) begin
      m = r;
      if (m < inner_r) m = inner_r;
      if (m > outer_r) m = outer_r;
      sc = 32'((64'(m - inner_r) * 32768) / (outer_r - inner_r));
      if (sc > 32768) sc = 32768;
      res.clean_x = component(x, sc, r);
      res.clean_y = component(y, sc, r);
    end
    pending.insert(pending.size(), res);
  endfunction

  function void check_result(srdz_pkg::out_item_t got);
    srdz_pkg::out_item_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: expected dev %0d stk %0d x %0d y %0d, ",
                  "got dev %0d stk %0d x %0d y %0d"},
                 want.out_device, want.out_stick, want.clean_x, want.clean_y,
                 got.out_device, got.out_stick, got.clean_x, got.clean_y);
    end
  endfunction
endclass

module tb_stick_radial_deadzone_core;
  import srdz_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  in_item_t in_item = '0;
  logic in_valid = 0;
  logic in_stall;
  out_item_t out_item;
  logic out_valid;
  logic out_stall = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [0:0] cfg_index = CFG_INNER;
  logic [15:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  deadzone_scoreboard board = new();

  always #1 clk = ~clk;

  stick_radial_deadzone_core u_top (.*);

  // Receiver: random stall, check every accepted beat.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_item);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send_event(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    board.note_event(it);
  endtask

  function automatic in_item_t make_event(int d, int s, int a, int n, int v);
    in_item_t it;
    it.device_index = 2'(d);
    it.stick_index = 2'(s);
    it.axis_index = 1'(a);
    it.negative_dir = 1'(n);
    it.axis_value = 15'(v);
    return it;
  endfunction

  function automatic in_item_t rand_event();
    int v;
    case ($urandom_range(3))
      0: v = $urandom_range(32767);
      1: v = $urandom_range(32767, 30000);
      2: v = $urandom_range(300);
      default: v = ($urandom_range(1) != 0) ? 32767 : 0;
    endcase
    return make_event($urandom_range(3), $urandom_range(3), $urandom_range(1),
                      $urandom_range(1), v);
  endfunction

  task automatic run_random(int count);
    repeat (count) send_event(rand_event());
    in_valid <= 0;
  endtask

  initial begin
    #100000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: extremes, zero radius, diagonal, dead band.
    send_event(make_event(0, 0, 0, 0, 0));
    send_event(make_event(0, 0, 0, 0, 32767));
    send_event(make_event(0, 0, 1, 1, 32767));
    send_event(make_event(0, 0, 0, 1, 32767));
    send_event(make_event(3, 3, 1, 0, 1));
    send_event(make_event(3, 3, 0, 1, 1));
    send_event(make_event(1, 2, 0, 0, 32767));
    send_event(make_event(1, 2, 0, 0, 0));
    send_event(make_event(2, 1, 1, 1, 23170));
    send_event(make_event(2, 1, 0, 0, 23170));
    in_valid <= 0;
    drain();
    write_reg(CFG_INNER, 16'd4000);
    write_reg(CFG_OUTER, 16'd30000);
    send_event(make_event(2, 1, 0, 1, 2000));
    send_event(make_event(2, 1, 1, 0, 100));
    send_event(make_event(2, 1, 0, 0, 32767));
    in_valid <= 0;
    drain();
    write_reg(CFG_OUTER, 16'd4000);
    send_event(make_event(0, 3, 0, 0, 20000));
    in_valid <= 0;
    drain();
    write_reg(CFG_INNER, 16'hffff);
    write_reg(CFG_OUTER, 16'h0000);
    send_event(make_event(0, 3, 1, 1, 20000));
    in_valid <= 0;
    drain();

    send_idle_pct = 14;
    recv_idle_pct = 69;
    write_reg(CFG_INNER, 16'd0);
    write_reg(CFG_OUTER, 16'hffff);
    run_random(250);
    drain();
    send_idle_pct = 69;
    recv_idle_pct = 14;
    write_reg(CFG_INNER, 16'd3000);
    write_reg(CFG_OUTER, 16'd32768);
    run_random(250);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_INNER, 16'd0);
    write_reg(CFG_OUTER, 16'd1);
    run_random(100);
    drain();
    write_reg(CFG_INNER, 16'd8000);
    write_reg(CFG_OUTER, 16'd24000);
    run_random(400);
    drain();

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/srdz_pkg.sv
rtl/srdz_front.sv
rtl/srdz_queue.sv
rtl/srdz_back.sv
rtl/stick_radial_deadzone_core.sv
tb/sv/tb_stick_radial_deadzone_core.sv
